### rtl/ptmb_pkg.sv
// Package for the page table map builder: control word, branch conditions,
// step codes and the microcode ROM. No dependencies.
package ptmb_pkg;

  localparam int STEP_W = 3;

  localparam logic [STEP_W-1:0] STEP_CLEAR = 3'd0;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_READ  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_CHECK = 3'd3;
  localparam logic [STEP_W-1:0] STEP_LEAF  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_FIN   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_RETRY = 3'd6;

  localparam logic [31:0] BASE_RESET     = 32'h0003_0000;
  localparam logic [63:0] LEAF_ATTR_MASK = 64'h8000_0000_0000_011E;
  localparam logic [11:0] TABLE_FLAGS    = 12'h003;  // present | writable

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_CLEAR_BUSY,
    COND_WALK_MORE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic              clear_wr;
    logic              accept;
    logic              rd;
    logic              check;
    logic              leaf;
    logic              fin;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic no_input;
    logic clear_busy;
    logic walk_more;
    logic out_free;
  } flags_t;

  function automatic ctrl_word_t ptmb_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '0;
    unique case (step)
      STEP_CLEAR: begin
        cw.clear_wr = 1'b1;
        cw.cond     = COND_CLEAR_BUSY;
        cw.target   = STEP_CLEAR;
      end
      STEP_IDLE: begin
        cw.accept = 1'b1;
        cw.cond   = COND_NO_INPUT;
        cw.target = STEP_IDLE;
      end
      STEP_READ: begin
        cw.rd   = 1'b1;
        cw.cond = COND_NEXT;
      end
      STEP_CHECK: begin
        cw.check  = 1'b1;
        cw.cond   = COND_WALK_MORE;
        cw.target = STEP_READ;
      end
      STEP_LEAF: begin
        cw.leaf = 1'b1;
        cw.cond = COND_NEXT;
      end
      STEP_FIN: begin
        cw.fin    = 1'b1;
        cw.cond   = COND_OUT_FREE;
        cw.target = STEP_IDLE;
      end
      STEP_RETRY: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_FIN;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

### rtl/ptmb_req_if.sv
// Request channel: one mapping request per transaction.
// Stand-alone; no package use.
interface ptmb_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] physical_address;
  logic [47:0] virtual_address;
  logic [63:0] attributes;

  modport source(output valid, physical_address, virtual_address, attributes,
                 input ready);
  modport sink(input valid, physical_address, virtual_address, attributes,
               output ready);
endinterface

### rtl/ptmb_rsp_if.sv
// Response channel: one mapping result per transaction.
// Stand-alone; no package use.
interface ptmb_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] leaf_entry;
  logic [31:0] entry_address;
  logic [1:0]  tables_added;

  modport source(output valid, status, leaf_entry, entry_address, tables_added,
                 input ready);
  modport sink(input valid, status, leaf_entry, entry_address, tables_added,
               output ready);
endinterface

### rtl/ptmb_cfg_if.sv
// Configuration write channel for the root table base address.
// Stand-alone; no package use.
interface ptmb_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] table_base_addr;

  modport source(output valid, table_base_addr, input ready);
  modport sink(input valid, table_base_addr, output ready);
endinterface

### rtl/ptmb_table_store.sv
// Single-port table store with registered read data.
// Depends on nothing; sized by the top level.
module ptmb_table_store #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [63:0]   wdata,
  output logic [63:0]   rdata
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/ptmb_sequencer.sv
// Microcode sequencer: step counter, ROM lookup, conditional jumps.
// Uses ptmb_pkg for the ROM, control word and flags.
module ptmb_sequencer
  import ptmb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  flags_t     flags,
  output ctrl_word_t ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take_jump;

  assign ctrl = ptmb_rom(step);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEXT:       take_jump = 1'b0;
      COND_ALWAYS:     take_jump = 1'b1;
      COND_NO_INPUT:   take_jump = flags.no_input;
      COND_CLEAR_BUSY: take_jump = flags.clear_busy;
      COND_WALK_MORE:  take_jump = flags.walk_more;
      COND_OUT_FREE:   take_jump = flags.out_free;
      default:         take_jump = 1'b0;
    endcase
    step_next = take_jump ? ctrl.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_CLEAR;
    end else begin
      step <= step_next;
    end
  end

endmodule

### rtl/ptmb_datapath.sv
// Walk datapath: request latch, table pointer, allocator, result and
// output registers, store port steering. Driven by the control word.
// Uses ptmb_pkg and the three channel interfaces.
module ptmb_datapath
  import ptmb_pkg::*;
#(
  parameter int TABLE_PAGES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ctrl_word_t                     ctrl,
  output flags_t                         flags,
  ptmb_req_if.sink                       req,
  ptmb_rsp_if.source                     rsp,
  ptmb_cfg_if.sink                       cfg,
  output logic                           mem_we,
  output logic [$clog2(TABLE_PAGES)+8:0] mem_addr,
  output logic [63:0]                    mem_wdata,
  input  logic [63:0]                    mem_rdata
);

  localparam int PW    = $clog2(TABLE_PAGES);
  localparam int NFW   = $clog2(TABLE_PAGES + 1);
  localparam int AW    = PW + 9;
  localparam int DEPTH = TABLE_PAGES * 512;

  logic [31:0]    base_addr;
  logic [AW-1:0]  clr_cnt;
  logic [NFW-1:0] next_free;

  logic [63:0]    phys;
  logic [47:12]   va;
  logic [63:0]    attr;
  logic [1:0]     level;
  logic [PW-1:0]  page;
  logic [1:0]     added;
  logic           err;

  logic           res_status;
  logic [63:0]    res_leaf;
  logic [31:0]    res_eaddr;
  logic           out_valid;

  logic [8:0]     idx;
  logic           present;
  logic           no_free;
  logic           alloc;
  logic [19:0]    base_hi;
  logic [19:0]    new_hi;
  logic [19:0]    entry_hi;
  logic [19:0]    diff;
  logic           oob;
  logic           err_now;
  logic [63:0]    leaf_val;

  assign base_hi = base_addr[31:12];

  always_comb begin
    case (level)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      default: idx = va[29:21];
    endcase
  end

  // upper-level entry check; read data belongs to the read issued last step
  assign present  = mem_rdata[0];
  assign no_free  = !present && (next_free == NFW'(TABLE_PAGES));
  assign alloc    = ctrl.check && !present && !no_free;
  assign new_hi   = base_hi + 20'(next_free);
  assign entry_hi = present ? mem_rdata[31:12] : new_hi;
  assign diff     = entry_hi - base_hi;
  assign oob      = diff >= 20'(TABLE_PAGES);
  assign err_now  = no_free || oob;

  assign leaf_val = {phys[63:12], 12'h000} | attr | 64'd1;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {page, idx};
    mem_wdata = {32'd0, new_hi, TABLE_FLAGS};
    if (ctrl.clear_wr) begin
      mem_we    = 1'b1;
      mem_addr  = clr_cnt;
      mem_wdata = '0;
    end else if (ctrl.check) begin
      mem_we = alloc;
    end else if (ctrl.leaf) begin
      mem_we    = !err;
      mem_addr  = {page, va[20:12]};
      mem_wdata = leaf_val;
    end
  end

  assign flags.no_input   = !req.valid;
  assign flags.clear_busy = clr_cnt != AW'(DEPTH - 1);
  assign flags.walk_more  = !err_now && (level != 2'd2);
  assign flags.out_free   = !out_valid || rsp.ready;

  assign req.ready = ctrl.accept;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr <= BASE_RESET;
      clr_cnt   <= '0;
      next_free <= NFW'(1);
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        base_addr <= cfg.table_base_addr;
      end
      if (ctrl.clear_wr && flags.clear_busy) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (alloc) begin
        next_free <= next_free + 1'b1;
      end
      if (ctrl.fin && flags.out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    if (ctrl.accept && req.valid) begin
      phys  <= req.physical_address;
      va    <= req.virtual_address[47:12];
      attr  <= req.attributes & LEAF_ATTR_MASK;
      level <= 2'd0;
      page  <= '0;
      added <= 2'd0;
      err   <= 1'b0;
    end
    if (ctrl.check) begin
      err   <= err_now;
      level <= level + 2'd1;
      if (alloc) begin
        added <= added + 2'd1;
      end
      if (!err_now) begin
        page <= diff[PW-1:0];
      end
    end
    if (ctrl.leaf) begin
      res_status <= err;
      res_leaf   <= err ? 64'd0 : leaf_val;
      res_eaddr  <= err ? 32'd0 : {base_hi + 20'(page), va[20:12], 3'b000};
    end
    if (ctrl.fin && flags.out_free) begin
      rsp.status        <= res_status;
      rsp.leaf_entry    <= res_leaf;
      rsp.entry_address <= res_eaddr;
      rsp.tables_added  <= added;
    end
  end

endmodule

### rtl/page_table_map_builder_core.sv
// Top level of the four-level page table map builder.
// Uses ptmb_pkg, the channel interfaces, sequencer, datapath and table store.
//
//   channel  dir  payload                                           handshake
//   req      in   physical_address, virtual_address, attributes     valid/ready
//   rsp      out  status, leaf_entry, entry_address, tables_added   valid/ready
//   cfg      in   table_base_addr                                   valid/ready
//
// A mapping steps through accept, then read and check (with allocate) for each
// of the three upper levels through the single-port table store, then the leaf
// write, then hand-off. An error stops the walk early.
// After reset a clearing pass zeroes all TABLE_PAGES*512 entries of the store
// (32768 at default) with req.ready low; cfg writes are taken throughout.
// The result sits in an output register; a new request is taken while it
// waits, and the hand-off step waits only if that register is still full.
module page_table_map_builder_core
  import ptmb_pkg::*;
#(
  parameter int TABLE_PAGES = 64
) (
  input  logic       clk,
  input  logic       rst,
  ptmb_req_if.sink   req,
  ptmb_rsp_if.source rsp,
  ptmb_cfg_if.sink   cfg
);

  localparam int AW = $clog2(TABLE_PAGES) + 9;

  ctrl_word_t    ctrl;
  flags_t        flags;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [63:0]   mem_wdata;
  logic [63:0]   mem_rdata;

  ptmb_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  ptmb_datapath #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .flags     (flags),
    .req       (req),
    .rsp       (rsp),
    .cfg       (cfg),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  ptmb_table_store #(
    .DEPTH (TABLE_PAGES * 512),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for page_table_map_builder_core: drives mapping requests and
// table base writes, predicts each leaf write, entry address and table count.
// Depends on ptmb_pkg and the req, rsp and cfg channel interfaces.
`timescale 1ns / 100ps

module tb_top
  import ptmb_pkg::*;
();

  localparam int TABLE_PAGES    = 64;
  localparam int ENTRIES        = 512;
  localparam int CLK_PERIOD     = 8;
  localparam int DRAIN_CYCLES   = 16;
  localparam int TIMEOUT_CYCLES = 500_000;
  localparam int PTE_PRESENT    = 0;
  localparam logic MAP_OK       = 1'b0;
  localparam logic MAP_FAILED   = 1'b1;

  typedef struct packed {
    logic        status;
    logic [63:0] leaf_entry;
    logic [31:0] entry_address;
    logic [1:0]  tables_added;
  } map_result_t;

  logic clk;
  logic rst;

  ptmb_req_if req_bus ();
  ptmb_rsp_if rsp_bus ();
  ptmb_cfg_if cfg_bus ();

  page_table_map_builder_core #(.TABLE_PAGES(TABLE_PAGES)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  // shadow copy of the block's table store and allocator
  logic [63:0] table_mem [0:TABLE_PAGES*ENTRIES-1];
  int unsigned next_free_table;
  logic [31:0] table_base;

  map_result_t expected_maps[$];
  logic [26:0] prefix_pool[$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_idle_pct;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) begin
    rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic map_result_t predict_mapping(input logic [63:0] pa,
                                                  input logic [47:0] va,
                                                  input logic [63:0] attr);
    map_result_t r;
    logic [31:0] abase;
    logic [31:0] nxt;
    logic [63:0] ent;
    int unsigned pg;
    int unsigned slot;
    r = '0;
    abase = {table_base[31:12], 12'h000};
    pg = 0;
    for (int lvl = 0; lvl < 3; lvl++) begin
      slot = pg * ENTRIES + int'(va[39 - 9*lvl +: 9]);
      ent = table_mem[slot];
      if (!ent[PTE_PRESENT]) begin
        if (next_free_table >= TABLE_PAGES) begin
          r.status = MAP_FAILED;
          return r;
        end
        ent = {32'h0, abase + (32'(next_free_table) << 12)} | {52'h0, TABLE_FLAGS};
        table_mem[slot] = ent;
        next_free_table++;
        r.tables_added = r.tables_added + 2'd1;
      end
      // only bits 31..12 of the entry name the next table
      nxt = ({ent[31:12], 12'h000} - abase) >> 12;
      if (nxt >= 32'(TABLE_PAGES)) begin
        r.status = MAP_FAILED;
        return r;
      end
      pg = nxt;
    end
    r.status        = MAP_OK;
    r.leaf_entry    = {pa[63:12], 12'h000} | (attr & LEAF_ATTR_MASK) | 64'h1;
    r.entry_address = abase + (32'(pg) << 12) + {20'h0, va[20:12], 3'b000};
    table_mem[pg * ENTRIES + int'(va[20:12])] = r.leaf_entry;
    return r;
  endfunction

  function automatic int first_absent(input int unsigned pg);
    for (int i = 0; i < ENTRIES; i++) begin
      if (!table_mem[pg * ENTRIES + i][PTE_PRESENT]) return i;
    end
    return -1;
  endfunction

  // valid stays high between back-to-back transactions; it drops only while idling
  task automatic send_mapping(input logic [63:0] pa, input logic [47:0] va,
                              input logic [63:0] attr);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid            <= 1'b1;
    req_bus.physical_address <= pa;
    req_bus.virtual_address  <= va;
    req_bus.attributes       <= attr;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    expected_maps.push_back(predict_mapping(pa, va, attr));
    if (prefix_pool.size() < 64) prefix_pool.push_back(va[47:21]);
    else prefix_pool[$urandom_range(63)] = va[47:21];
  endtask

  task automatic release_request();
    @(negedge clk);
    req_bus.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (expected_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_base(input logic [31:0] base);
    wait_for_results();
    @(negedge clk);
    cfg_bus.valid           <= 1'b1;
    cfg_bus.table_base_addr <= base;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    table_base = base;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic test_directed_walks();
    send_mapping(64'h0, 48'h0, 64'h0);
    send_mapping('1, 48'h0000_0000_1000, '1);
    send_mapping(64'h0000_0001_2345_6FFF, 48'hFFFF_FFFF_FFFF, LEAF_ATTR_MASK);
    // remap of the same page: walk finds every level present
    send_mapping(64'hFFFF_0000_FFFF_0000, 48'hFFFF_FFFF_FFFF, ~LEAF_ATTR_MASK);
    send_mapping(64'h0000_0000_0000_1000, 48'h0000_0020_0000, 64'h2);
    send_mapping(64'h8000_0000_0000_0000, 48'h0000_4000_0000, 64'h4);
    send_mapping(64'h7FFF_FFFF_FFFF_F000, 48'hAAAA_AAAA_A000, 64'h8);
    send_mapping(64'hAAAA_AAAA_AAAA_AAAA, 48'h5555_5555_5FFF, 64'h10);
    send_mapping(64'h5555_5555_5555_5555, 48'h0000_0000_0FFF, 64'h100);
    send_mapping(64'h1234_5678_9ABC_DEF0, 48'h8000_0000_0000, 64'h8000_0000_0000_0000);
    send_mapping(64'hFEDC_BA98_7654_3210, 48'h7FFF_FFFF_F000, 64'h1);
    send_mapping(64'h0F0F_0F0F_0F0F_0F0F, 48'h0000_001F_F000, 64'hFFFF_FFFF_FFFF_FEE1);
    release_request();
  endtask

  task automatic test_random_mapping(input int count, input int fresh_pct,
                                     input int reidx_pct);
    logic [47:0] va;
    logic [63:0] pa;
    logic [63:0] attr;
    logic [26:0] pfx;
    int          pick;
    repeat (count) begin
      pick = $urandom_range(99);
      va   = 48'({$urandom, $urandom});
      pfx  = prefix_pool[$urandom_range(prefix_pool.size() - 1)];
      // mostly known prefixes so the walk goes through existing tables
      if (pick >= fresh_pct) begin
        va[47:30] = pfx[26:9];
        if (pick >= fresh_pct + reidx_pct) va[29:21] = pfx[8:0];
      end
      pa   = {$urandom, $urandom};
      attr = {$urandom, $urandom};
      if ($urandom_range(1) == 0) attr = attr & LEAF_ATTR_MASK;
      send_mapping(pa, va, attr);
    end
    release_request();
  endtask

  // page 2 is the third-level table under prefix zero, from the first directed walk
  task automatic test_table_exhaustion();
    int spare;
    int idx;
    spare = TABLE_PAGES - int'(next_free_table);
    while (spare > 0) begin
      if (spare % 3 == 0) begin
        idx = first_absent(2);
        send_mapping({$urandom, $urandom}, {18'h0, 9'(idx), 21'($urandom)}, '1);
      end else begin
        idx = first_absent(0);
        send_mapping({$urandom, $urandom}, {9'(idx), 39'({$urandom, $urandom})}, '1);
      end
      spare = TABLE_PAGES - int'(next_free_table);
    end
    idx = first_absent(0);
    send_mapping({$urandom, $urandom}, {9'(idx), 39'h12_3456_7000}, 64'h2);
    idx = first_absent(2);
    send_mapping({$urandom, $urandom}, {18'h0, 9'(idx), 21'h0_5000}, 64'h2);
    send_mapping(64'hCAFE_0000_0000_0000, 48'h0, 64'h2);
    release_request();
  endtask

  always @(posedge clk) begin : result_check
    map_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_maps.size() == 0) begin
        report_mismatch("result transaction with no request outstanding");
      end else begin
        want = expected_maps.pop_front();
        if (rsp_bus.status !== want.status)
          report_mismatch($sformatf("status got %0b expected %0b",
                                    rsp_bus.status, want.status));
        if (rsp_bus.leaf_entry !== want.leaf_entry)
          report_mismatch($sformatf("leaf_entry got %h expected %h",
                                    rsp_bus.leaf_entry, want.leaf_entry));
        if (rsp_bus.entry_address !== want.entry_address)
          report_mismatch($sformatf("entry_address got %h expected %h",
                                    rsp_bus.entry_address, want.entry_address));
        if (rsp_bus.tables_added !== want.tables_added)
          report_mismatch($sformatf("tables_added got %0d expected %0d",
                                    rsp_bus.tables_added, want.tables_added));
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("page_table_map_builder_core test failed");
    $finish;
  end

  initial begin
    rst                      = 1'b1;
    req_bus.valid            = 1'b0;
    req_bus.physical_address = '0;
    req_bus.virtual_address  = '0;
    req_bus.attributes       = '0;
    rsp_bus.ready            = 1'b0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.table_base_addr  = '0;
    for (int i = 0; i < TABLE_PAGES * ENTRIES; i++) table_mem[i] = '0;
    next_free_table = 1;
    table_base      = BASE_RESET;
    mismatch_count  = 0;
    send_idle_pct   = 17;
    recv_idle_pct   = 81;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_walks();
    write_table_base(32'h0003_0FFF);   // low bits ignored, tree stays valid
    test_random_mapping(150, 2, 8);
    test_table_exhaustion();

    send_idle_pct = 81;
    recv_idle_pct = 17;
    write_table_base(32'h0002_F000);   // every table decodes one page higher
    test_random_mapping(200, 10, 10);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_table_base(32'hFFFF_FFFF);   // old entries wrap round to high pages
    test_random_mapping(130, 10, 10);
    write_table_base(32'h0000_0000);
    test_random_mapping(100, 10, 10);

    wait_for_results();
    if (mismatch_count == 0) begin
      $display("page_table_map_builder_core test passed");
    end else begin
      $display("page_table_map_builder_core test failed");
    end
    $finish;
  end

endmodule
